### hdl/lgps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgps_pkg
// Shared types and constants for the gait phase scheduler.
// ----------------------------------------------------------------------------
package lgps_pkg;

  localparam int LEG_COUNT     = 4;
  localparam int FRACTION_BITS = 16;
  localparam int TIME_BITS     = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 64;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_CYCLE_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_FRACTION = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INIT_STANCE   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_OFFSETS = 2'd3;

  // Leg status codes.
  localparam logic [1:0] ST_SWING  = 2'd0;
  localparam logic [1:0] ST_STANCE = 2'd1;
  localparam logic [1:0] ST_EARLY  = 2'd2;
  localparam logic [1:0] ST_LOST   = 2'd3;

  typedef struct packed {
    logic [31:0] now_time;
    logic [3:0]  contact_mask;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  desired_stance_mask;
    logic [7:0]  leg_status;
    logic [15:0] phase_leg0;
    logic [15:0] phase_leg1;
    logic [15:0] phase_leg2;
    logic [15:0] phase_leg3;
  } out_item_t;

  // Configuration snapshot handed down the pipeline.
  typedef struct packed {
    logic [31:0]           period;
    logic [15:0]           duty;
    logic [3:0]            init_stance;
    logic [CFG_DATA_BITS-1:0] offsets;
  } cfg_t;

  // One step of a restoring fraction division: remainder grows by a bit.
  typedef struct packed {
    logic [32:0] rem;
    logic [15:0] quo;
  } div_step_t;

  function automatic div_step_t div_step32(input div_step_t s, input logic [31:0] d);
    div_step_t r;
    logic [33:0] sh;
    sh = {s.rem, 1'b0};
    r.quo = {s.quo[14:0], 1'b0};
    if (sh >= {2'b00, d}) begin
      r.rem = 33'(sh - {2'b00, d});
      r.quo[0] = 1'b1;
    end else begin
      r.rem = sh[32:0];
    end
    return r;
  endfunction

endpackage

### hdl/lgps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgps_front
// Accepts a request, reduces the time stamp modulo the period and turns it
// into a Q0.16 cycle phase through a pipelined restoring divider.
// ----------------------------------------------------------------------------
module lgps_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  lgps_pkg::in_item_t  in_data,
  input  lgps_pkg::cfg_t      cfg,
  input  logic                advance,
  output logic                f_valid,
  output logic [15:0]         f_time_frac,
  output logic [3:0]          f_contact
);
  // Stage layout: 0 = first modulo step, 1..31 further modulo steps (one bit
  // each), then 16 fraction steps. Modulo is done as restoring remainder, bit
  // serial across stages, MSB first.
  localparam int MS = 32;
  localparam int FS = 16;
  localparam int NS = MS + FS;

  logic [NS-1:0]  vld_r;
  logic [32:0]    rem_r  [NS];
  logic [31:0]    num_r  [NS];
  logic [15:0]    quo_r  [NS];
  logic [3:0]     con_r  [NS];

  // Pipeline moves only when the queue can take the oldest entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    lgps_pkg::div_step_t s;
    logic [33:0] sh;
    if (advance) begin
      // First modulo step.
      sh = {33'd0, in_data.now_time[31]};
      rem_r[0] <= (sh >= {2'b00, cfg.period}) ? 33'(sh - {2'b00, cfg.period}) : sh[32:0];
      num_r[0] <= {in_data.now_time[30:0], 1'b0};
      quo_r[0] <= '0;
      con_r[0] <= in_data.contact_mask;
      for (int k = 1; k < NS; k++) begin
        con_r[k] <= con_r[k-1];
        if (k < MS) begin
          sh = {rem_r[k-1], num_r[k-1][31]};
          rem_r[k] <= (sh >= {2'b00, cfg.period}) ? 33'(sh - {2'b00, cfg.period})
                                                   : sh[32:0];
          num_r[k] <= {num_r[k-1][30:0], 1'b0};
          quo_r[k] <= '0;
        end else begin
          s.rem = rem_r[k-1];
          s.quo = quo_r[k-1];
          s = lgps_pkg::div_step32(s, cfg.period);
          rem_r[k] <= s.rem;
          quo_r[k] <= s.quo;
          num_r[k] <= num_r[k-1];
        end
      end
    end
  end

  // A zero period yields a zero time term.
  assign f_valid     = vld_r[NS-1];
  assign f_time_frac = (cfg.period == '0) ? 16'd0 : quo_r[NS-1];
  assign f_contact   = con_r[NS-1];
endmodule

### hdl/lgps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgps_queue
// Two-entry queue between the phase front end and the per-leg back end.
// ----------------------------------------------------------------------------
module lgps_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [19:0] wr_data,
  output logic        full,
  input  logic        rd_en,
  output logic        not_empty,
  output logic [19:0] rd_data
);
  logic [19:0] mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= 2'(cnt_r + {1'b0, wr_en} - {1'b0, rd_en});
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign full      = cnt_r[1];
  assign not_empty = cnt_r != 2'd0;
  assign rd_data   = mem_r[rp_r];
endmodule

### hdl/lgps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgps_back
// Per-leg segment classification and segment phase division, pipelined over
// sixteen quotient stages, with an output register at the end.
// ----------------------------------------------------------------------------
module lgps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                b_valid,
  input  logic [19:0]         b_data,
  output logic                b_ready,
  input  lgps_pkg::cfg_t      cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output lgps_pkg::out_item_t out_data
);
  localparam int NL = lgps_pkg::LEG_COUNT;
  localparam int NS = 17;

  logic [NS-1:0] vld_r;
  logic [16:0]   rem_r [NS][NL];
  logic [16:0]   div_r [NS][NL];
  logic [15:0]   quo_r [NS][NL];
  logic [NL-1:0] stn_r [NS];
  logic [3:0]    con_r [NS];
  logic          advance;

  // Pipeline stalls while the output register holds a result that is not taken.
  assign advance = !out_valid || out_ready;
  assign b_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) vld_r <= {vld_r[NS-2:0], b_valid};
      if (advance) out_valid <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [15:0] ph;
    logic [16:0] ratio;
    logic [17:0] sh;
    logic        ss;
    if (advance) begin
      // Stage 0: phase, ratio and segment choice.
      con_r[0] <= b_data[3:0];
      for (int i = 0; i < NL; i++) begin
        ss    = cfg.init_stance[i];
        ph    = 16'(b_data[19:4] + cfg.offsets[i*16 +: 16]);
        ratio = ss ? {1'b0, cfg.duty} : 17'(17'h10000 - {1'b0, cfg.duty});
        quo_r[0][i] <= '0;
        if ({1'b0, ph} < ratio) begin
          stn_r[0][i] <= ss;
          rem_r[0][i] <= {1'b0, ph};
          div_r[0][i] <= ratio;
        end else begin
          stn_r[0][i] <= ~ss;
          rem_r[0][i] <= 17'({1'b0, ph} - ratio);
          div_r[0][i] <= 17'(17'h10000 - ratio);
        end
      end
      // Stages 1..16: one quotient bit per stage and leg.
      for (int k = 1; k < NS; k++) begin
        con_r[k] <= con_r[k-1];
        stn_r[k] <= stn_r[k-1];
        for (int i = 0; i < NL; i++) begin
          sh = {rem_r[k-1][i], 1'b0};
          div_r[k][i] <= div_r[k-1][i];
          if (div_r[k-1][i] != '0 && sh >= {1'b0, div_r[k-1][i]}) begin
            rem_r[k][i] <= 17'(sh - {1'b0, div_r[k-1][i]});
            quo_r[k][i] <= {quo_r[k-1][i][14:0], 1'b1};
          end else begin
            rem_r[k][i] <= sh[16:0];
            quo_r[k][i] <= {quo_r[k-1][i][14:0], 1'b0};
          end
        end
      end
      // Output register.
      out_data.desired_stance_mask <= stn_r[NS-1];
      for (int i = 0; i < NL; i++) begin
        case ({stn_r[NS-1][i], con_r[NS-1][i]})
          2'b00:   out_data.leg_status[2*i +: 2] <= lgps_pkg::ST_SWING;
          2'b01:   out_data.leg_status[2*i +: 2] <= lgps_pkg::ST_EARLY;
          2'b10:   out_data.leg_status[2*i +: 2] <= lgps_pkg::ST_LOST;
          default: out_data.leg_status[2*i +: 2] <= lgps_pkg::ST_STANCE;
        endcase
      end
      out_data.phase_leg0 <= quo_r[NS-1][0];
      out_data.phase_leg1 <= quo_r[NS-1][1];
      out_data.phase_leg2 <= quo_r[NS-1][2];
      out_data.phase_leg3 <= quo_r[NS-1][3];
    end
  end
endmodule

### hdl/legged_gait_phase_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legged_gait_phase_scheduler
// Gait phase scheduler for four legs: from a time stamp and contact bits it
// derives stance mask, per-leg status and segment phase.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry a request {now_time, contact_mask}; out_valid/
//   out_ready carry the result. cfg_we/cfg_index/cfg_data write registers
//   while the block is idle: 0 cycle_period, 1 duty_fraction,
//   2 initial_stance_mask, 3 phase_offsets.
//   Throughput: one request per cycle while the receiver takes results. The path
//   has 48 stages in the front (32 modulo bit steps and 16 fraction bit steps of
//   the period divider) and 17 back stages (ratio compare plus 16 segment
//   quotient steps), plus queue and output register.
//   A two-entry queue parts the front from the back. When the receiver
//   stalls, the back holds, the queue fills and the front and in_ready then
//   stop; no request is lost.
//   Synchronous reset clears all valid flags and loads register defaults.
// ----------------------------------------------------------------------------
module legged_gait_phase_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lgps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lgps_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [lgps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lgps_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  lgps_pkg::cfg_t cfg_r;
  logic        f_valid, advance, q_full, q_ne, b_ready;
  logic [15:0] f_frac;
  logic [3:0]  f_con;
  logic [19:0] q_rd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period      <= 32'd600000;
      cfg_r.duty        <= 16'd32768;
      cfg_r.init_stance <= 4'd6;
      cfg_r.offsets     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lgps_pkg::REG_CYCLE_PERIOD:  cfg_r.period      <= cfg_data[31:0];
        lgps_pkg::REG_DUTY_FRACTION: cfg_r.duty        <= cfg_data[15:0];
        lgps_pkg::REG_INIT_STANCE:   cfg_r.init_stance <= cfg_data[3:0];
        lgps_pkg::REG_PHASE_OFFSETS: cfg_r.offsets     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front advances when its tail can enter the queue.
  assign advance  = !(f_valid && q_full);
  assign in_ready = advance;

  lgps_front u_front (
    .clk, .rst_n, .in_valid, .in_data, .cfg(cfg_r), .advance,
    .f_valid, .f_time_frac(f_frac), .f_contact(f_con)
  );

  lgps_queue u_queue (
    .clk, .rst_n,
    .wr_en(f_valid && advance), .wr_data({f_frac, f_con}), .full(q_full),
    .rd_en(q_ne && b_ready), .not_empty(q_ne), .rd_data(q_rd)
  );

  lgps_back u_back (
    .clk, .rst_n, .b_valid(q_ne), .b_data(q_rd), .b_ready, .cfg(cfg_r),
    .out_valid, .out_ready, .out_data
  );

`ifndef SYNTH
  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // A full queue with a waiting front item must stop the input.
  a_backpress: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && q_full |-> !in_ready)
    else $error("input taken while queue full");
  // The queue is never written when full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !(f_valid && advance))
    else $error("queue overflow");
`endif
endmodule

### test/legged_gait_phase_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legged_gait_phase_scheduler_test
// Self-checking bench for the gait phase scheduler. A directed table of
// requests is followed by random requests under several register settings.
// Every result is compared field by field with a typed-in result or an in-bench gait predictor.
// ----------------------------------------------------------------------------
module legged_gait_phase_scheduler_test;

  localparam int LATENCY     = 80;
  localparam int CYCLE_LIMIT = 400000;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  lgps_pkg::in_item_t                  in_data = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  lgps_pkg::out_item_t                 out_data;
  logic                                cfg_we = 1'b0;
  logic [lgps_pkg::CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [lgps_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Predictor copy of the registers.
  logic [31:0] gait_period;
  logic [15:0] gait_duty;
  logic [3:0]  gait_init_stance;
  logic [63:0] gait_offsets;

  lgps_pkg::out_item_t expected_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // One directed row: request, and an optional typed-in result.
  typedef struct {
    logic [31:0]         now_time;
    logic [3:0]          contact;
    bit                  has_known;
    lgps_pkg::out_item_t known;
  } gait_row_t;

  legged_gait_phase_scheduler i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // floor(x * 2^16 / d) for x < d.
  function automatic logic [15:0] fraction_quotient(logic [63:0] x, logic [63:0] d);
    logic [63:0] r;
    logic [15:0] q;
    r = x;
    q = '0;
    if (d == 0) return '0;
    for (int b = 0; b < lgps_pkg::FRACTION_BITS; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Schedule of all four legs for one time stamp and contact mask.
  function automatic lgps_pkg::out_item_t predict_gait(logic [31:0] now_time,
                                                       logic [3:0] contact);
    lgps_pkg::out_item_t res;
    logic [15:0] time_frac;
    logic [15:0] cyc;
    logic [16:0] ratio;
    logic [15:0] seg[4];
    logic        stance;
    logic [1:0]  st;
    res = '0;
    time_frac = '0;
    if (gait_period != 0)
      time_frac = fraction_quotient(64'(now_time % gait_period), 64'(gait_period));
    for (int i = 0; i < lgps_pkg::LEG_COUNT; i++) begin
      cyc = time_frac + gait_offsets[i*16 +: 16];
      ratio = gait_init_stance[i] ? {1'b0, gait_duty} : 17'h10000 - gait_duty;
      if ({1'b0, cyc} < ratio) begin
        stance = gait_init_stance[i];
        seg[i] = fraction_quotient(64'(cyc), 64'(ratio));
      end else begin
        stance = ~gait_init_stance[i];
        seg[i] = fraction_quotient(64'(cyc) - 64'(ratio), 64'h10000 - 64'(ratio));
      end
      if (stance) st = contact[i] ? lgps_pkg::ST_STANCE : lgps_pkg::ST_LOST;
      else st = contact[i] ? lgps_pkg::ST_EARLY : lgps_pkg::ST_SWING;
      res.desired_stance_mask[i] = stance;
      res.leg_status[2*i +: 2] = st;
    end
    res.phase_leg0 = seg[0];
    res.phase_leg1 = seg[1];
    res.phase_leg2 = seg[2];
    res.phase_leg3 = seg[3];
    return res;
  endfunction

  // Write enable stays high across back-to-back writes; the caller drops it.
  task automatic write_register(logic [lgps_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      lgps_pkg::REG_CYCLE_PERIOD:  gait_period = value[31:0];
      lgps_pkg::REG_DUTY_FRACTION: gait_duty = value[15:0];
      lgps_pkg::REG_INIT_STANCE:   gait_init_stance = value[3:0];
      default:                     gait_offsets = value;
    endcase
  endtask

  task automatic configure_gait(logic [31:0] period, logic [15:0] duty, logic [3:0] stance,
                                logic [63:0] offsets);
    write_register(lgps_pkg::REG_CYCLE_PERIOD, 64'(period));
    write_register(lgps_pkg::REG_DUTY_FRACTION, 64'(duty));
    write_register(lgps_pkg::REG_INIT_STANCE, 64'(stance));
    write_register(lgps_pkg::REG_PHASE_OFFSETS, offsets);
    cfg_we <= 1'b0;
  endtask

  // Present one request and hold it until accepted; queue its expectation.
  task automatic send_request(logic [31:0] now_time, logic [3:0] contact, bit has_known,
                              lgps_pkg::out_item_t known);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{now_time: now_time, contact_mask: contact};
    expected_results.push_back(has_known ? known : predict_gait(now_time, contact));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Random time stamps: near period boundaries, within the first period, or anywhere.
  function automatic logic [31:0] random_time();
    case ($urandom_range(3))
      0: return gait_period * $urandom_range(7) + $urandom_range(2) - 1;
      1: return $urandom_range(gait_period == 0 ? 100 : gait_period);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++)
      send_request(random_time(), 4'($urandom()), 1'b0, '0);
  endtask

  // Receiver: random stalls at the configured rate, and the result check.
  always @(posedge clk) begin
    lgps_pkg::out_item_t exp_item;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", out_data);
          error_count++;
        end else begin
          exp_item = expected_results.pop_front();
          if (out_data.desired_stance_mask !== exp_item.desired_stance_mask) begin
            $error("desired_stance_mask expected %h actual %h",
                   exp_item.desired_stance_mask, out_data.desired_stance_mask);
            error_count++;
          end
          if (out_data.leg_status !== exp_item.leg_status) begin
            $error("leg_status expected %h actual %h", exp_item.leg_status,
                   out_data.leg_status);
            error_count++;
          end
          if (out_data.phase_leg0 !== exp_item.phase_leg0) begin
            $error("phase_leg0 expected %h actual %h", exp_item.phase_leg0,
                   out_data.phase_leg0);
            error_count++;
          end
          if (out_data.phase_leg1 !== exp_item.phase_leg1) begin
            $error("phase_leg1 expected %h actual %h", exp_item.phase_leg1,
                   out_data.phase_leg1);
            error_count++;
          end
          if (out_data.phase_leg2 !== exp_item.phase_leg2) begin
            $error("phase_leg2 expected %h actual %h", exp_item.phase_leg2,
                   out_data.phase_leg2);
            error_count++;
          end
          if (out_data.phase_leg3 !== exp_item.phase_leg3) begin
            $error("phase_leg3 expected %h actual %h", exp_item.phase_leg3,
                   out_data.phase_leg3);
            error_count++;
          end
        end
      end
      out_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL legged_gait_phase_scheduler");
      $finish;
    end
  end

  initial begin
    gait_row_t rows[$];
    gait_row_t row;
    gait_period = 32'd600000;
    gait_duty = 16'd32768;
    gait_init_stance = 4'd6;
    gait_offsets = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset at time zero: legs 1 and 2 in stance, all segment phases zero.
    row = '{32'd0, 4'b0000, 1'b1, '{4'b0110,
            {lgps_pkg::ST_SWING, lgps_pkg::ST_LOST, lgps_pkg::ST_LOST, lgps_pkg::ST_SWING},
            16'd0, 16'd0, 16'd0, 16'd0}};
    rows.push_back(row);
    row = '{32'd0, 4'b1111, 1'b1, '{4'b0110,
            {lgps_pkg::ST_EARLY, lgps_pkg::ST_STANCE, lgps_pkg::ST_STANCE,
             lgps_pkg::ST_EARLY},
            16'd0, 16'd0, 16'd0, 16'd0}};
    rows.push_back(row);
    // Exactly half a cycle: every leg switches to its second segment.
    row = '{32'd300000, 4'b0110, 1'b1, '{4'b1001,
            {lgps_pkg::ST_LOST, lgps_pkg::ST_EARLY, lgps_pkg::ST_EARLY, lgps_pkg::ST_LOST},
            16'd0, 16'd0, 16'd0, 16'd0}};
    rows.push_back(row);
    row = '{32'hFFFFFFFF, 4'b1010, 1'b0, '0}; rows.push_back(row);
    row = '{32'd599999, 4'b0101, 1'b0, '0}; rows.push_back(row);
    row = '{32'd600000, 4'b0011, 1'b0, '0}; rows.push_back(row);
    row = '{32'd150000, 4'b1100, 1'b0, '0}; rows.push_back(row);
    row = '{32'h80000000, 4'b1001, 1'b0, '0}; rows.push_back(row);
    row = '{32'h55555555, 4'b0110, 1'b0, '0}; rows.push_back(row);
    row = '{32'hAAAAAAAA, 4'b1111, 1'b0, '0}; rows.push_back(row);
    foreach (rows[k]) send_request(rows[k].now_time, rows[k].contact, rows[k].has_known,
                                   rows[k].known);
    drain_results();

    // Zero period: the cycle phase is the offset alone; zero duty fraction too.
    configure_gait(32'd0, 16'd0, 4'b0101, 64'hFFFF_8000_0001_0000);
    for (int n = 0; n < 6; n++) send_request($urandom(), 4'($urandom()), 1'b0, '0);
    drain_results();
    // Extremes: largest period, duty one lsb and all ones.
    configure_gait(32'hFFFFFFFF, 16'd1, 4'b1111, 64'h0);
    for (int n = 0; n < 5; n++) send_request(random_time(), 4'($urandom()), 1'b0, '0);
    send_request(32'hFFFFFFFF, 4'hF, 1'b0, '0);
    drain_results();
    configure_gait(32'd1, 16'hFFFF, 4'b0000, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int n = 0; n < 5; n++) send_request($urandom(), 4'($urandom()), 1'b0, '0);
    drain_results();

    // Random settings under three idling patterns.
    for (int p = 0; p < 12; p++) begin
      case (p / 4)
        0: begin send_idle_pct = 20; recv_idle_pct = 74; end
        1: begin send_idle_pct = 74; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p % 4)
        0: configure_gait($urandom_range(1, 1000), 16'($urandom_range(1, 65535)),
                          4'($urandom()), {$urandom(), $urandom()});
        1: configure_gait($urandom(), 16'($urandom_range(1, 65535)), 4'($urandom()),
                          {$urandom(), $urandom()});
        2: configure_gait($urandom_range(100000, 2000000), 16'($urandom()), 4'($urandom()),
                          {$urandom(), $urandom()});
        default: configure_gait(32'($urandom_range(1, 3)) << $urandom_range(0, 30),
                                16'($urandom()), 4'($urandom()), {$urandom(), $urandom()});
      endcase
      random_phase(140);
      drain_results();
    end

    if (error_count == 0) begin
      $display("PASS legged_gait_phase_scheduler");
    end else begin
      $display("FAIL legged_gait_phase_scheduler");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lgps_pkg.sv
hdl/lgps_front.sv
hdl/lgps_queue.sv
hdl/lgps_back.sv
hdl/legged_gait_phase_scheduler.sv
test/legged_gait_phase_scheduler_test.sv
